// File: rtl/xpfe_pkg.sv
// ----------------------------------------------------------------------------
// XOR pair parity FEC encoder - shared package
// Widths, codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package xpfe_pkg;

    localparam int PAYLOAD_WORDS_DEF = 40;
    localparam int SEQ_W             = 32;
    localparam int WORD_W            = 32;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_PARITY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_CLEAR,
        S_PAR_RD,
        S_PAR_OUT
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take;       // input beat accepted
        logic wr_word;    // write (or fold) the held word into the store
        logic clr_wr;     // zero one tail entry of the store
        logic par_rd;     // read one parity entry
        logic par_load;   // push parity entry into the output register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic last;       // current word ends the frame
        logic pair;       // current frame folds into the store
        logic pos_last;   // word position at the final slot
        logic idx_last;   // sweep index at the final slot
        logic out_free;   // output register can take a beat this cycle
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/xpfe_stream_if.sv
// ----------------------------------------------------------------------------
// XOR pair parity FEC encoder - stream interfaces
// Input frame-word channel and output packet-word channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface xpfe_in_if import xpfe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SEQ_W-1:0]  frame_seq;
    logic [WORD_W-1:0] payload_word;
    logic              frame_end;

    modport source (output valid, output frame_seq, output payload_word,
                    output frame_end, input ready);
    modport sink   (input valid, input frame_seq, input payload_word,
                    input frame_end, output ready);
endinterface

interface xpfe_out_if import xpfe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              packet_kind;
    logic [SEQ_W-1:0]  header_seq;
    logic [WORD_W-1:0] out_word;
    logic              packet_end;

    modport source (output valid, output packet_kind, output header_seq,
                    output out_word, output packet_end, input ready);
    modport sink   (input valid, input packet_kind, input header_seq,
                    input out_word, input packet_end, output ready);
endinterface

`default_nettype wire

// File: rtl/xpfe_datapath.sv
// ----------------------------------------------------------------------------
// XOR pair parity FEC encoder - datapath
// Payload store, sequence bookkeeping, sweep index and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module xpfe_datapath import xpfe_pkg::*; #(
    parameter int PAYLOAD_WORDS = PAYLOAD_WORDS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    input  wire logic [SEQ_W-1:0]  i_frame_seq,
    input  wire logic [WORD_W-1:0] i_payload_word,
    input  wire logic              i_frame_end,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_packet_kind,
    output logic [SEQ_W-1:0]       o_header_seq,
    output logic [WORD_W-1:0]      o_out_word,
    output logic                   o_packet_end
);

    localparam int IDX_W = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_WORDS - 1);

    logic [WORD_W-1:0] r_mem [PAYLOAD_WORDS];
    logic [WORD_W-1:0] r_rdata;
    logic [WORD_W-1:0] r_word;

    logic [IDX_W-1:0]  r_pos;
    logic [IDX_W-1:0]  r_idx;
    logic              r_pair;
    logic              r_last;
    logic [SEQ_W-1:0]  r_held_seq;
    logic              r_held_valid;

    logic              r_out_valid;
    logic              r_kind;
    logic [SEQ_W-1:0]  r_hseq;
    logic [WORD_W-1:0] r_oword;
    logic              r_oend;

    logic              n_pair_hit;
    logic              n_last;
    logic              n_pos_last;
    logic              n_idx_last;

    always_comb begin
        n_pos_last = (r_pos == LAST_IDX);
        n_idx_last = (r_idx == LAST_IDX);
        n_last     = i_frame_end || n_pos_last;
        n_pair_hit = r_held_valid && (i_frame_seq == r_held_seq + SEQ_W'(1))
                     && i_frame_seq[0];
    end

    assign o_sts.last     = r_last;
    assign o_sts.pair     = r_pair;
    assign o_sts.pos_last = n_pos_last;
    assign o_sts.idx_last = n_idx_last;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_word) begin
            r_mem[r_pos] <= r_pair ? (r_rdata ^ r_word) : r_word;
        end else if (i_cmd.clr_wr) begin
            r_mem[r_idx] <= '0;
        end
        if (i_cmd.take) begin
            r_rdata <= r_mem[r_pos];
            r_word  <= i_payload_word;
        end else if (i_cmd.par_rd) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_idx        <= '0;
            r_pair       <= 1'b0;
            r_last       <= 1'b0;
            r_held_seq   <= '0;
            r_held_valid <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_last <= n_last;
                // pairing decided on the first beat of a frame only
                if (r_pos == '0) begin
                    r_pair <= n_pair_hit;
                    if (!n_pair_hit) begin
                        r_held_seq   <= i_frame_seq;
                        r_held_valid <= 1'b1;
                    end
                end
            end
            if (i_cmd.wr_word) begin
                r_idx <= r_pair ? '0 : r_pos + IDX_W'(1);
                if (r_last) begin
                    r_pos  <= '0;
                    r_pair <= 1'b0;
                end else begin
                    r_pos  <= r_pos + IDX_W'(1);
                end
            end
            if (i_cmd.clr_wr) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.par_load) begin
                r_idx <= r_idx + IDX_W'(1);
                if (n_idx_last) begin
                    r_held_valid <= 1'b0;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.take || i_cmd.par_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_kind  <= KIND_DATA;
            r_hseq  <= i_frame_seq;
            r_oword <= i_payload_word;
            r_oend  <= n_last;
        end else if (i_cmd.par_load) begin
            r_kind  <= KIND_PARITY;
            r_hseq  <= r_held_seq;
            r_oword <= r_rdata;
            r_oend  <= n_idx_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_packet_kind = r_kind;
    assign o_header_seq  = r_hseq;
    assign o_out_word    = r_oword;
    assign o_packet_end  = r_oend;

endmodule

`default_nettype wire

// File: rtl/xpfe_ctrl.sv
// ----------------------------------------------------------------------------
// XOR pair parity FEC encoder - controller
// Sequences beat intake, store update, tail clearing and parity burst.
// ----------------------------------------------------------------------------
`default_nettype none

module xpfe_ctrl import xpfe_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n && i_sts.out_free;
                if (i_in_valid && o_in_ready) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.wr_word = 1'b1;
                if (i_sts.last && i_sts.pair) begin
                    n_state = S_PAR_RD;
                end else if (i_sts.last && !i_sts.pos_last) begin
                    n_state = S_CLEAR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_PAR_RD: begin
                o_cmd.par_rd = 1'b1;
                n_state      = S_PAR_OUT;
            end
            S_PAR_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.par_load = 1'b1;
                    n_state        = i_sts.idx_last ? S_IDLE : S_PAR_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/xor_pair_parity_fec_encoder_top.sv
// ----------------------------------------------------------------------------
// XOR pair parity FEC encoder - top level
// Forwards frame words as data packets and emits an XOR parity packet after
// each odd frame that follows its stored predecessor.
// ----------------------------------------------------------------------------
//  port      dir  beat
//  i_frame   in   frame_seq, payload_word, frame_end
//  o_pkt     out  packet_kind, header_seq, out_word, packet_end
//
//  Each input beat is an accept followed by a store read-modify-write.
//  A stored frame ending short is padded by one store write per cycle over
//  the PAYLOAD_WORDS-1-pos tail slots. A paired frame's end adds a parity
//  burst of PAYLOAD_WORDS beats, each a store read then an output load.
//  Reset is synchronous; the store itself is not cleared.
//  A stall on o_pkt holds the output register and blocks intake.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_pair_parity_fec_encoder_top import xpfe_pkg::*; #(
    parameter int PAYLOAD_WORDS = PAYLOAD_WORDS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    xpfe_in_if.sink    i_frame,
    xpfe_out_if.source o_pkt
);

    t_cmd w_cmd;
    t_sts w_sts;

    xpfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_frame.valid),
        .o_in_ready (i_frame.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    xpfe_datapath #(
        .PAYLOAD_WORDS (PAYLOAD_WORDS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_frame_seq    (i_frame.frame_seq),
        .i_payload_word (i_frame.payload_word),
        .i_frame_end    (i_frame.frame_end),
        .i_out_ready    (o_pkt.ready),
        .o_out_valid    (o_pkt.valid),
        .o_packet_kind  (o_pkt.packet_kind),
        .o_header_seq   (o_pkt.header_seq),
        .o_out_word     (o_pkt.out_word),
        .o_packet_end   (o_pkt.packet_end)
    );

endmodule

`default_nettype wire

// File: rtl/xpfe_checker.sv
// ----------------------------------------------------------------------------
// XOR pair parity FEC encoder - port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module xpfe_checker import xpfe_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic [WORD_W-1:0] i_payload_word,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic              i_packet_kind,
    input wire logic [SEQ_W-1:0]  i_header_seq,
    input wire logic [WORD_W-1:0] i_out_word
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // an accepted beat shows up as a data word on the next cycle
    a_data_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=>
            (i_out_valid && i_packet_kind == KIND_DATA
             && i_out_word == $past(i_payload_word)))
        else $error("accepted beat not forwarded as data word");

    // intake closes for the store update after each beat
    a_gap_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("intake open during store update");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_word) && $stable(i_header_seq)
             && $stable(i_packet_kind)))
        else $error("stalled output beat changed");

endmodule

bind xor_pair_parity_fec_encoder_top xpfe_checker u_xpfe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_frame.valid),
    .i_in_ready     (i_frame.ready),
    .i_payload_word (i_frame.payload_word),
    .i_out_valid    (o_pkt.valid),
    .i_out_ready    (o_pkt.ready),
    .i_packet_kind  (o_pkt.packet_kind),
    .i_header_seq   (o_pkt.header_seq),
    .i_out_word     (o_pkt.out_word)
);

`default_nettype wire
